// ----- design/rrs_pkg.sv -----
// Package for the rank range selection block.
// Holds widths, status codes, the register map and the configuration struct.
// No dependencies.
package rrs_pkg;

    localparam int DATA_W            = 32;
    localparam int K_W               = 6;
    localparam int STATUS_W          = 2;
    localparam int DEFAULT_MAX_ITEMS = 64;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_RANK = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // Register index is taken from paddr bit 2.
    localparam logic REG_K_LOW  = 1'b0;
    localparam logic REG_K_HIGH = 1'b1;

    typedef struct packed {
        logic [K_W-1:0] k_low;
        logic [K_W-1:0] k_high;
    } cfg_t;

endpackage

// ----- design/rrs_cmp.sv -----
// Signed compare unit of the rank range selection block.
// Depends on rrs_pkg.
module rrs_cmp
    import rrs_pkg::*;
(
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              a_gt_b
);

    // Two's complement ordering of the stored element against the new one.
    assign a_gt_b = $signed(a) > $signed(b);

endmodule

// ----- design/rrs_store.sv -----
// Element memory of the rank range selection block: one write port and one
// read port with registered read data. Depends on rrs_pkg.
module rrs_store
    import rrs_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_ITEMS,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rrs_regs.sv -----
// APB register file of the rank range selection block: k_low and k_high.
// Depends on rrs_pkg.
module rrs_regs
    import rrs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_K_LOW:  cfg_reg.k_low  <= pwdata[K_W-1:0];
                REG_K_HIGH: cfg_reg.k_high <= pwdata[K_W-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_K_LOW:  prdata = APB_DATA_W'(cfg_reg.k_low);
            REG_K_HIGH: prdata = APB_DATA_W'(cfg_reg.k_high);
            default:    prdata = '0;
        endcase
    end

endmodule

// ----- design/rank_range_select.sv -----
// Top level of the rank range selection block: sequencer, insertion control
// and output register. Depends on rrs_pkg, rrs_cmp, rrs_store and rrs_regs.
//
//  Channel  | Direction | Contents
//  ---------+-----------+--------------------------------------------------
//  s_axis   | in        | tdata = value[31:0], tlast = last_item
//  m_axis   | out       | tdata = value_res[31:0], tuser = status, tlast = last_result
//  APB      | in/out    | 0x0 k_low[5:0], 0x4 k_high[5:0]
//
//  An element is inserted by walking down from the top of the sorted memory,
//  one read and one compare per element moved; a dropped element skips the
//  walk and goes straight to ST_CHECK. Each selected result is read through
//  the memory read port (ST_SEL_RD, then ST_SEL_OUT) and waits in ST_SEL_OUT
//  while the output register is full and m_tready is low. Reset clears the
//  state, the count, the overflow flag, the output valid and the APB registers;
//  memory contents need no clearing.
module rank_range_select
    import rrs_pkg::*;
#(
    parameter int MAX_ITEMS = DEFAULT_MAX_ITEMS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: value[31:0]
    input  logic [DATA_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // m_tdata: value_res[31:0]
    output logic [DATA_W-1:0]     m_tdata,
    // m_tuser: status[1:0]
    output logic [STATUS_W-1:0]   m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW   = $clog2(MAX_ITEMS);
    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int CW   = (CNTW > K_W) ? CNTW : K_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_RD,
        ST_SHIFT_CMP,
        ST_PLACE,
        ST_CHECK,
        ST_ERR_OUT,
        ST_SEL_RD,
        ST_SEL_OUT
    } state_t;

    state_t              state_reg;
    logic [CNTW-1:0]     count_reg;
    logic                overflow_reg;
    logic [AW-1:0]       pos_reg;
    logic [DATA_W-1:0]   value_reg;
    logic                last_reg;
    logic [K_W-1:0]      rank_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [DATA_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic                m_tlast_reg;
    logic                m_tvalid_reg;

    cfg_t                cfg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;
    logic                stored_gt;
    logic                s_accept;
    logic                out_free;
    logic                out_load;
    logic                rank_bad;

    rrs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rrs_store #(
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rrs_cmp u_cmp (
        .a      (mem_rdata),
        .b      (value_reg),
        .a_gt_b (stored_gt)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    // A new result enters the output register in this cycle.
    assign out_load = out_free && (state_reg == ST_ERR_OUT || state_reg == ST_SEL_OUT);
    assign rank_bad = (cfg.k_low > cfg.k_high) || (CW'(cfg.k_high) >= CW'(count_reg));

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

    // The read address is held for as long as the state needs the data.
    always_comb begin
        unique case (state_reg)
            ST_SEL_RD, ST_SEL_OUT: mem_raddr = AW'(rank_reg);
            default:               mem_raddr = pos_reg - AW'(1);
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = value_reg;
        unique case (state_reg)
            ST_SHIFT_CMP: begin
                mem_we = 1'b1;
                if (stored_gt) begin
                    mem_wdata = mem_rdata;
                end
            end
            ST_PLACE: mem_we = 1'b1;
            default:  mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        value_reg <= s_tdata;
                        last_reg  <= s_tlast;
                        pos_reg   <= AW'(count_reg);
                        if (count_reg == CNTW'(MAX_ITEMS)) begin
                            overflow_reg <= 1'b1;
                            state_reg    <= ST_CHECK;
                        end else if (count_reg == '0) begin
                            state_reg <= ST_PLACE;
                        end else begin
                            state_reg <= ST_SHIFT_RD;
                        end
                    end
                end
                ST_SHIFT_RD: state_reg <= ST_SHIFT_CMP;
                ST_SHIFT_CMP: begin
                    if (stored_gt) begin
                        // The larger element moved up one slot; keep walking down.
                        pos_reg <= pos_reg - AW'(1);
                        if (pos_reg == AW'(1)) begin
                            state_reg <= ST_PLACE;
                        end else begin
                            state_reg <= ST_SHIFT_RD;
                        end
                    end else begin
                        count_reg <= count_reg + CNTW'(1);
                        state_reg <= ST_CHECK;
                    end
                end
                ST_PLACE: begin
                    count_reg <= count_reg + CNTW'(1);
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (rank_bad) begin
                        state_reg <= ST_ERR_OUT;
                    end else begin
                        rank_reg   <= cfg.k_low;
                        status_reg <= overflow_reg ? STATUS_OVERFLOW : STATUS_OK;
                        state_reg  <= ST_SEL_RD;
                    end
                end
                ST_ERR_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= '0;
                        m_tuser_reg  <= STATUS_BAD_RANK;
                        m_tlast_reg  <= 1'b1;
                        m_tvalid_reg <= 1'b1;
                        count_reg    <= '0;
                        overflow_reg <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_SEL_RD: state_reg <= ST_SEL_OUT;
                ST_SEL_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= mem_rdata;
                        m_tuser_reg  <= status_reg;
                        m_tlast_reg  <= (rank_reg == cfg.k_high);
                        m_tvalid_reg <= 1'b1;
                        if (rank_reg == cfg.k_high) begin
                            count_reg    <= '0;
                            overflow_reg <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end else begin
                            rank_reg  <= rank_reg + K_W'(1);
                            state_reg <= ST_SEL_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/rrs_checker.sv -----
// Port-level checker for the rank range selection block, bound to the top.
// Depends on rrs_pkg.
module rrs_checker
    import rrs_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic [DATA_W-1:0]   m_tdata,
    input logic [STATUS_W-1:0] m_tuser,
    input logic                m_tlast,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic                pready
);

    // A rank error is a single, zero-valued, final transaction.
    a_bad_rank_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STATUS_BAD_RANK) |-> (m_tlast && m_tdata == '0))
        else $error("rank error result is not a lone zero transaction");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_BAD_RANK ||
                      m_tuser == STATUS_OVERFLOW))
        else $error("undefined status code on result");

    // Every result of one run carries the same status.
    a_status_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid |->
            (m_tuser == $past(m_tuser) || $past(m_tuser) == STATUS_BAD_RANK))
        else $error("status changed within a run");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready dropped");

endmodule

bind rank_range_select rrs_checker u_rrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .pready   (pready)
);

// ----- tb/sv/rank_range_select_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for rank_range_select: streams data sets under changing
// rank windows and compares every result with a sorted-list predictor.
// Depends on rrs_pkg and the rank_range_select RTL.
module rank_range_select_test
    import rrs_pkg::*;
();

    localparam int     CLK_PERIOD    = 12;
    localparam int     CAPACITY      = DEFAULT_MAX_ITEMS;
    localparam int     SETTLE_CYCLES = 160;
    localparam int     RANDOM_ITEMS  = 450;
    localparam int     HOLD_CYCLES   = 500;
    localparam longint TIMEOUT_NS    = 64'd12_000_000;

    typedef struct {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
        logic                last;
    } selection_t;

    // Keeps the current data set sorted and queues the selections it will produce.
    class selection_board;
        logic [K_W-1:0] k_low   = '0;
        logic [K_W-1:0] k_high  = '0;
        int             sorted_set[$];
        bit             dropped = 1'b0;
        selection_t     awaited[$];
        int             errors  = 0;

        function void set_reg(input logic reg_idx, input logic [APB_DATA_W-1:0] word);
            if (reg_idx == REG_K_LOW)
                k_low = word[K_W-1:0];
            else
                k_high = word[K_W-1:0];
        endfunction

        function void note_input(input logic [DATA_W-1:0] v, input logic last_item);
            int                  pos;
            int                  r;
            selection_t          sel;
            logic [STATUS_W-1:0] st;
            if (sorted_set.size() < CAPACITY) begin
                pos = sorted_set.size();
                while (pos > 0 && sorted_set[pos-1] > $signed(v))
                    pos--;
                sorted_set.insert(pos, $signed(v));
            end else begin
                dropped = 1'b1;
            end
            if (!last_item)
                return;
            if (k_low > k_high || int'(k_high) >= sorted_set.size()) begin
                sel.value  = '0;
                sel.status = STATUS_BAD_RANK;
                sel.last   = 1'b1;
                awaited    = {awaited, sel};
            end else begin
                st = dropped ? STATUS_OVERFLOW : STATUS_OK;
                for (r = int'(k_low); r <= int'(k_high); r++) begin
                    sel.value  = sorted_set[r];
                    sel.status = st;
                    sel.last   = (r == int'(k_high));
                    awaited    = {awaited, sel};
                end
            end
            sorted_set.delete();
            dropped = 1'b0;
        endfunction

        function void check_result(input logic [DATA_W-1:0] value,
                                   input logic [STATUS_W-1:0] status, input logic last);
            selection_t exp_sel;
            if (awaited.size() == 0) begin
                $error("unexpected result: value_res %h status %0d last_result %0b",
                       value, status, last);
                errors++;
                return;
            end
            exp_sel = awaited.pop_front();
            if (value !== exp_sel.value) begin
                $error("value_res: expected %h, got %h", exp_sel.value, value);
                errors++;
            end
            if (status !== exp_sel.status) begin
                $error("status: expected %0d, got %0d", exp_sel.status, status);
                errors++;
            end
            if (last !== exp_sel.last) begin
                $error("last_result: expected %0b, got %0b", exp_sel.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [DATA_W-1:0]     s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    selection_board board;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             hold_request  = 0;
    int             hold_left     = 0;
    int             directed_vals[$];

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    rank_range_select #(.MAX_ITEMS(CAPACITY)) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Result side: check each transaction, then choose the ready level for the next edge.
    // A hold request keeps ready low for a long stretch so the block backs up.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser, m_tlast);
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom();
        endcase
    endfunction

    // Valid stays high after a transaction; the next call either idles or offers new data.
    task automatic send_item(input logic [DATA_W-1:0] v, input logic last_item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last_item;
        do @(posedge aclk); while (!s_tready);
        board.note_input(v, last_item);
    endtask

    task automatic send_set(input int count);
        int i;
        for (i = 0; i < count; i++)
            send_item(pick_value(), i == count - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.awaited.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Upper data bits are random; only the low rank bits should take effect.
    task automatic write_reg(input logic reg_idx, input logic [K_W-1:0] val);
        logic [APB_DATA_W-1:0] word;
        word         = $urandom();
        word[K_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_reg(reg_idx, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input int lo, input int hi);
        write_reg(REG_K_LOW, K_W'(lo));
        write_reg(REG_K_HIGH, K_W'(hi));
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 76; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 9;  stall_pct = 9;  end
        endcase
    endtask

    task automatic run_directed(input int lo, input int hi);
        int i;
        configure(lo, hi);
        for (i = 0; i < directed_vals.size(); i++)
            send_item(directed_vals[i], i == directed_vals.size() - 1);
        drain();
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int items_sent;
        int phase;
        int set_len;
        int n_sets;
        int lo;
        int hi;
        board = new;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(0);
        // Single most negative element.
        directed_vals = '{32'h8000_0000};
        run_directed(0, 0);
        // Both extremes and zero.
        directed_vals = '{32'h7fff_ffff, 32'h8000_0000, 0};
        run_directed(0, 1);
        // Duplicates are ranked one copy at a time.
        directed_vals = '{5, 5, -1, 5};
        run_directed(1, 3);
        // Low rank above high rank.
        directed_vals = '{1, 2, 3};
        run_directed(2, 1);
        // High rank past the element count.
        directed_vals = '{9, 8, 7};
        run_directed(3, 3);
        directed_vals = '{-1, 1};
        run_directed(63, 63);

        items_sent = 0;
        phase      = 0;
        // Every idling phase runs at least once.
        while (items_sent < RANDOM_ITEMS || phase < 4) begin
            case (phase)
                0: begin lo = 0;  hi = 63; end
                1: begin lo = 63; hi = 63; end
                default: begin
                    case ($urandom_range(0, 5))
                        0: begin lo = 0; hi = 0; end
                        1: begin lo = 0; hi = 63; end
                        2: begin
                            lo = $urandom_range(1, 63);
                            hi = $urandom_range(0, lo - 1);
                        end
                        default: begin
                            lo = $urandom_range(0, 4);
                            hi = lo + $urandom_range(0, 6);
                        end
                    endcase
                end
            endcase
            configure(lo, hi);
            set_idling(phase % 4);
            if (phase == 2)
                hold_request = HOLD_CYCLES;
            n_sets = (hi >= 60) ? 1 : $urandom_range(2, 6);
            repeat (n_sets) begin
                if (hi >= 60)
                    set_len = $urandom_range(62, 68);
                else if ($urandom_range(0, 9) == 0)
                    set_len = $urandom_range(60, 70);
                else
                    set_len = $urandom_range(1, 12);
                send_set(set_len);
                items_sent += set_len;
                if ($urandom_range(0, 4) == 0)
                    drain();
            end
            drain();
            phase++;
        end

        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
